>>> rtl/lli_pkg.sv
// Shared types and codes for the line-line intersection unit.
// No dependencies; every other file of the unit imports this package.
package lli_pkg;

    // Result status codes carried on the result channel's tuser.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam int OUT_WIDTH = 32;

    // Sign and special-case flags that travel beside the magnitudes.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } lli_tag_t;

endpackage

>>> rtl/line_line_intersection_unit.sv
// Top level of the line-line intersection unit: front end, divider cell chain
// and output register. Depends on lli_pkg, lli_front and lli_div_cell.
//
//   channel   direction  tdata                          tuser
//   s_axis    request in line pair, 8 coordinates       -
//   m_axis    result out cross_x, cross_y               status
//
// One request is accepted per cycle when the pipeline can move. The pipeline
// has five front-end stages, one divider cell per quotient bit, and the
// output register. The divider chain sets the depth; each cell resolves one
// quotient bit of x and of y. Reset clears only the valid bits. Each stage
// holds when the next one is full and stalled, so bubbles close up and the
// input keeps flowing while the output waits. Coordinates are fixed point;
// the fraction bits cancel in the quotient, so the result comes back at the
// input scale with no extra shift.
module line_line_intersection_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // Fields from bit 0 up: a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y.
    input  logic [8*COORD_WIDTH-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // Fields from bit 0 up: cross_x, cross_y.
    output logic [63:0]              m_tdata,
    // Fields from bit 0 up: status.
    output logic [1:0]               m_tuser
);
    import lli_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int NW   = 2 * CW + 1;
    localparam int DENW = 2 * DW + 1;
    localparam int NUMW = NW + DW + 1;
    // Quotient extended to at least 33 bits for the saturation compares.
    localparam int QEW  = (NUMW > 33) ? NUMW : 33;

    logic                c_valid [NUMW+1];
    logic                c_ready [NUMW+1];
    logic [DENW-1:0]     c_den   [NUMW+1];
    logic [DENW-1:0]     c_rem_x [NUMW+1];
    logic [DENW-1:0]     c_rem_y [NUMW+1];
    logic [NUMW-1:0]     c_dq_x  [NUMW+1];
    logic [NUMW-1:0]     c_dq_y  [NUMW+1];
    lli_tag_t            c_tag   [NUMW+1];

    logic                out_valid_reg;
    logic                out_adv;
    logic [OUT_WIDTH-1:0] x_reg, y_reg, x_next, y_next;
    logic [1:0]           st_reg, st_next;
    logic [QEW-1:0]       qx, qy;
    logic                 sat_x, sat_y;

    lli_front #(
        .COORD_WIDTH(CW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_coords(s_tdata),
        .out_valid(c_valid[0]),
        .out_ready(c_ready[0]),
        .out_den  (c_den[0]),
        .out_num_x(c_dq_x[0]),
        .out_num_y(c_dq_y[0]),
        .out_tag  (c_tag[0])
    );

    // The partial remainders start at zero in front of the first cell.
    assign c_rem_x[0] = '0;
    assign c_rem_y[0] = '0;

    for (genvar i = 0; i < NUMW; i++)
    begin : g_cell
        lli_div_cell #(
            .DENW(DENW),
            .NUMW(NUMW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (c_valid[i]),
            .in_ready (c_ready[i]),
            .in_den   (c_den[i]),
            .in_rem_x (c_rem_x[i]),
            .in_rem_y (c_rem_y[i]),
            .in_dq_x  (c_dq_x[i]),
            .in_dq_y  (c_dq_y[i]),
            .in_tag   (c_tag[i]),
            .out_valid(c_valid[i+1]),
            .out_ready(c_ready[i+1]),
            .out_den  (c_den[i+1]),
            .out_rem_x(c_rem_x[i+1]),
            .out_rem_y(c_rem_y[i+1]),
            .out_dq_x (c_dq_x[i+1]),
            .out_dq_y (c_dq_y[i+1]),
            .out_tag  (c_tag[i+1])
        );
    end

    assign out_adv         = !out_valid_reg || m_tready;
    assign c_ready[NUMW]   = out_adv;

    // Sign, saturation and the zero-denominator case are applied here.
    // A negative quotient may reach 2^31; a positive one only 2^31 - 1.
    always_comb
    begin
        qx    = QEW'(c_dq_x[NUMW]);
        qy    = QEW'(c_dq_y[NUMW]);
        sat_x = c_tag[NUMW].neg_x ? (qx > QEW'(33'h0_8000_0000))
                                  : (qx > QEW'(33'h0_7FFF_FFFF));
        sat_y = c_tag[NUMW].neg_y ? (qy > QEW'(33'h0_8000_0000))
                                  : (qy > QEW'(33'h0_7FFF_FFFF));
        if (sat_x)
        begin
            x_next = c_tag[NUMW].neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            x_next = c_tag[NUMW].neg_x ? -qx[OUT_WIDTH-1:0] : qx[OUT_WIDTH-1:0];
        end
        if (sat_y)
        begin
            y_next = c_tag[NUMW].neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            y_next = c_tag[NUMW].neg_y ? -qy[OUT_WIDTH-1:0] : qy[OUT_WIDTH-1:0];
        end
        st_next = (sat_x || sat_y) ? ST_SAT : ST_OK;
        if (c_tag[NUMW].zero)
        begin
            x_next  = '0;
            y_next  = '0;
            st_next = ST_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= c_valid[NUMW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {y_reg, x_reg};
    assign m_tuser  = st_reg;

`ifndef SYNTHESIS
    // A zero denominator always gives a zero point.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_NONE) |-> (m_tdata == 64'd0))
        else $error("no-point result with nonzero coordinates");

    // A saturated status needs at least one coordinate at a limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SAT) |->
            (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000) ||
            (m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000))
        else $error("saturated status without a coordinate at a limit");

    // The input stalls only when the pipeline is backed up to the output.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output is free");

    // A held result stays put while the consumer stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
`endif

endmodule

>>> rtl/lli_front.sv
// Front end of the intersection unit: differences, cross products, numerators,
// magnitudes and signs in five elastic stages. Depends on lli_pkg.
module lli_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [8*COORD_WIDTH-1:0]             in_coords,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2*(COORD_WIDTH+1):0]           out_den,
    output logic [2*COORD_WIDTH+COORD_WIDTH+2:0] out_num_x,
    output logic [2*COORD_WIDTH+COORD_WIDTH+2:0] out_num_y,
    output lli_pkg::lli_tag_t                    out_tag
);
    import lli_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * CW;
    localparam int NW   = PW + 1;
    localparam int DPW  = 2 * DW;
    localparam int DENW = DPW + 1;
    localparam int NPW  = NW + DW;
    localparam int NUMW = NPW + 1;
    localparam int NST  = 5;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_in;
    logic [NST:0]   adv;

    logic signed [CW-1:0] c [8];

    // Stage 1
    logic signed [DW-1:0] s1_d_reg [4];
    logic signed [PW-1:0] s1_p_reg [4];
    // Stage 2
    logic signed [DW-1:0]  s2_d_reg [4];
    logic signed [DPW-1:0] s2_pd1_reg, s2_pd2_reg;
    logic signed [NW-1:0]  s2_n1_reg, s2_n2_reg;
    // Stage 3
    logic signed [DENW-1:0] s3_den_reg;
    logic signed [NPW-1:0]  s3_m_reg [4];
    // Stage 4
    logic signed [NUMW-1:0] s4_nx_reg, s4_ny_reg;
    logic [DENW-1:0]        s4_den_reg;
    logic                   s4_dneg_reg, s4_zero_reg;
    // Stage 5
    logic [DENW-1:0]        s5_den_reg;
    logic [NUMW-1:0]        s5_nx_reg, s5_ny_reg;
    lli_tag_t               s5_tag_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            c[i] = $signed(in_coords[i*CW +: CW]);
        end
    end

    always_comb
    begin
        adv[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end
    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NST-1];

    // Each stage takes the valid bit of the stage in front of it.
    assign valid_in = {valid_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_d_reg[0] <= DW'(c[0]) - DW'(c[2]);
            s1_d_reg[1] <= DW'(c[1]) - DW'(c[3]);
            s1_d_reg[2] <= DW'(c[4]) - DW'(c[6]);
            s1_d_reg[3] <= DW'(c[5]) - DW'(c[7]);
            s1_p_reg[0] <= PW'(c[0]) * PW'(c[3]);
            s1_p_reg[1] <= PW'(c[1]) * PW'(c[2]);
            s1_p_reg[2] <= PW'(c[4]) * PW'(c[7]);
            s1_p_reg[3] <= PW'(c[5]) * PW'(c[6]);
        end
        if (adv[1])
        begin
            s2_d_reg   <= s1_d_reg;
            s2_pd1_reg <= DPW'(s1_d_reg[0]) * DPW'(s1_d_reg[3]);
            s2_pd2_reg <= DPW'(s1_d_reg[1]) * DPW'(s1_d_reg[2]);
            s2_n1_reg  <= NW'(s1_p_reg[0]) - NW'(s1_p_reg[1]);
            s2_n2_reg  <= NW'(s1_p_reg[2]) - NW'(s1_p_reg[3]);
        end
        if (adv[2])
        begin
            s3_den_reg  <= DENW'(s2_pd1_reg) - DENW'(s2_pd2_reg);
            s3_m_reg[0] <= NPW'(s2_n1_reg) * NPW'(s2_d_reg[2]);
            s3_m_reg[1] <= NPW'(s2_n2_reg) * NPW'(s2_d_reg[0]);
            s3_m_reg[2] <= NPW'(s2_n1_reg) * NPW'(s2_d_reg[3]);
            s3_m_reg[3] <= NPW'(s2_n2_reg) * NPW'(s2_d_reg[1]);
        end
        if (adv[3])
        begin
            s4_nx_reg   <= NUMW'(s3_m_reg[0]) - NUMW'(s3_m_reg[1]);
            s4_ny_reg   <= NUMW'(s3_m_reg[2]) - NUMW'(s3_m_reg[3]);
            s4_den_reg  <= s3_den_reg[DENW-1] ? DENW'(-s3_den_reg) : DENW'(s3_den_reg);
            s4_dneg_reg <= s3_den_reg[DENW-1];
            s4_zero_reg <= (s3_den_reg == '0);
        end
        if (adv[4])
        begin
            s5_den_reg       <= s4_den_reg;
            s5_nx_reg        <= s4_nx_reg[NUMW-1] ? NUMW'(-s4_nx_reg) : NUMW'(s4_nx_reg);
            s5_ny_reg        <= s4_ny_reg[NUMW-1] ? NUMW'(-s4_ny_reg) : NUMW'(s4_ny_reg);
            s5_tag_reg.neg_x <= s4_nx_reg[NUMW-1] ^ s4_dneg_reg;
            s5_tag_reg.neg_y <= s4_ny_reg[NUMW-1] ^ s4_dneg_reg;
            s5_tag_reg.zero  <= s4_zero_reg;
        end
    end

    assign out_den   = s5_den_reg;
    assign out_num_x = s5_nx_reg;
    assign out_num_y = s5_ny_reg;
    assign out_tag   = s5_tag_reg;

endmodule

>>> rtl/lli_div_cell.sv
// One cell of the divider chain: a restoring step for x and y each,
// producing one quotient bit per coordinate. Depends on lli_pkg.
module lli_div_cell #(
    parameter int DENW = 35,
    parameter int NUMW = 51
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DENW-1:0]   in_den,
    input  logic [DENW-1:0]   in_rem_x,
    input  logic [DENW-1:0]   in_rem_y,
    input  logic [NUMW-1:0]   in_dq_x,
    input  logic [NUMW-1:0]   in_dq_y,
    input  lli_pkg::lli_tag_t in_tag,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DENW-1:0]   out_den,
    output logic [DENW-1:0]   out_rem_x,
    output logic [DENW-1:0]   out_rem_y,
    output logic [NUMW-1:0]   out_dq_x,
    output logic [NUMW-1:0]   out_dq_y,
    output lli_pkg::lli_tag_t out_tag
);
    import lli_pkg::*;

    logic            valid_reg;
    logic [DENW:0]   tx, ty;
    logic            ge_x, ge_y;
    logic [DENW-1:0] rem_x_next, rem_y_next;
    logic [DENW-1:0] den_reg, rem_x_reg, rem_y_reg;
    logic [NUMW-1:0] dq_x_reg, dq_y_reg;
    lli_tag_t        tag_reg;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb
    begin
        tx   = {in_rem_x, in_dq_x[NUMW-1]};
        ty   = {in_rem_y, in_dq_y[NUMW-1]};
        ge_x = (tx >= {1'b0, in_den});
        ge_y = (ty >= {1'b0, in_den});
        rem_x_next = ge_x ? DENW'(tx - {1'b0, in_den}) : tx[DENW-1:0];
        rem_y_next = ge_y ? DENW'(ty - {1'b0, in_den}) : ty[DENW-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            den_reg   <= in_den;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            dq_x_reg  <= {in_dq_x[NUMW-2:0], ge_x};
            dq_y_reg  <= {in_dq_y[NUMW-2:0], ge_y};
            tag_reg   <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_rem_x = rem_x_reg;
    assign out_rem_y = rem_y_reg;
    assign out_dq_x  = dq_x_reg;
    assign out_dq_y  = dq_y_reg;
    assign out_tag   = tag_reg;

endmodule

>>> tb/line_line_intersection_unit_tb.sv
// Testbench for the line-line intersection unit: directed table, then random line pairs.
// Depends on lli_pkg and line_line_intersection_unit; checks every result in order.
`timescale 1ns / 100ps

module line_line_intersection_unit_tb;
    import lli_pkg::*;

    localparam int CW = 16;

    // One result as the block should return it.
    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [1:0]         st;
    } crossing_t;

    // One directed row: eight coordinates, plus an optional typed-in answer.
    typedef struct {
        logic [8*CW-1:0] pts;
        bit              fixed;
        crossing_t       ans;
    } row_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [8*CW-1:0] s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [63:0]     m_tdata;
    logic [1:0]      m_tuser;

    crossing_t pending_crossings[$];
    int        errors;
    bit        send_calm;
    bit        recv_calm;

    line_line_intersection_unit #(.COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("line_line_intersection_unit_tb NOT OK");
        $finish;
    end

    // Saturates a 64-bit quotient to 32 bits and notes when it clipped.
    function automatic logic signed [31:0] clip32(input longint q, inout bit sat);
        if (q > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // Determinant form of the crossing point; every product is exact in 64 bits.
    function automatic crossing_t compute_crossing(input logic [8*CW-1:0] p);
        longint c[8];
        longint d1, d2, d3, d4, den, n1, n2;
        bit sat;
        crossing_t r;
        for (int i = 0; i < 8; i++)
            c[i] = longint'($signed(p[i*CW +: CW]));
        d1 = c[0] - c[2];
        d2 = c[1] - c[3];
        d3 = c[4] - c[6];
        d4 = c[5] - c[7];
        den = d1 * d4 - d2 * d3;
        sat = 1'b0;
        if (den == 0)
        begin
            r.cx = '0;
            r.cy = '0;
            r.st = ST_NONE;
            return r;
        end
        n1 = c[0] * c[3] - c[1] * c[2];
        n2 = c[4] * c[7] - c[5] * c[6];
        // SystemVerilog division of signed integers truncates toward zero.
        r.cx = clip32((n1 * d3 - n2 * d1) / den, sat);
        r.cy = clip32((n1 * d4 - n2 * d2) / den, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic logic [8*CW-1:0] pack_pts(input int v[8]);
        logic [8*CW-1:0] p;
        for (int i = 0; i < 8; i++)
            p[i*CW +: CW] = v[i][CW-1:0];
        return p;
    endfunction

    // Mostly well-posed pairs with small to medium coordinates, plus full-range noise,
    // coincident points and parallel lines.
    function automatic logic [8*CW-1:0] random_pair();
        int v[8];
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(16, 2000);
        for (int i = 0; i < 8; i++)
            v[i] = $urandom_range(0, 2 * span) - span;
        if (kind == 0)
            return {$urandom, $urandom, $urandom, $urandom};
        if (kind == 1)
        begin
            v[2] = v[0];
            v[3] = v[1];
        end
        else if (kind == 2)
        begin
            // Line B runs along half of line A's direction, so the two are
            // parallel or very nearly so.
            v[6] = v[4] + (v[2] - v[0]) / 2;
            v[7] = v[5] + (v[3] - v[1]) / 2;
            v[4] = v[4] - (v[2] - v[0]) / 2 + (v[2] - v[0]) / 2;
        end
        else if (kind == 3)
        begin
            // Nearly parallel lines push the crossing far away.
            v[6] = v[4] + (v[2] - v[0]);
            v[7] = v[5] + (v[3] - v[1]) + 1;
        end
        return pack_pts(v);
    endfunction

    // Drives one request from a falling edge and returns at the falling edge after
    // it was accepted; valid stays high so requests can follow back to back.
    task automatic send_pair(input logic [8*CW-1:0] p);
        while (!send_calm && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Ready toggles at random on falling edges, except in the calm stretch.
    always @(negedge clk)
        if (rst_n)
            m_tready <= recv_calm ? 1'b1 : ($urandom_range(0, 99) >= 30);

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_crossings.size() == 0)
            begin
                report_mismatch("result count", 1, 0);
            end
            else
            begin
                want = pending_crossings.pop_front();
                if (m_tdata[31:0] !== want.cx)
                    report_mismatch("cross_x", $signed(m_tdata[31:0]), want.cx);
                if (m_tdata[63:32] !== want.cy)
                    report_mismatch("cross_y", $signed(m_tdata[63:32]), want.cy);
                if (m_tuser !== want.st)
                    report_mismatch("status", m_tuser, want.st);
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        int   v[8];
        int   waited;
        errors    = 0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows. Axis lines crossing at the origin and at (16,16) are typed in.
        r.fixed = 1'b1;
        v = '{-16, 0, 16, 0, 0, -16, 0, 16};
        r.pts = pack_pts(v);
        r.ans = '{32'sd0, 32'sd0, ST_OK};
        rows.push_back(r);
        v = '{0, 16, 32, 16, 16, 0, 16, 32};
        r.pts = pack_pts(v);
        r.ans = '{32'sd16, 32'sd16, ST_OK};
        rows.push_back(r);
        // All zeros: both lines degenerate.
        r.pts = '0;
        r.ans = '{32'sd0, 32'sd0, ST_NONE};
        rows.push_back(r);
        // Identical extreme points.
        r.pts = {8{16'h7fff}};
        rows.push_back(r);
        r.pts = {8{16'h8000}};
        rows.push_back(r);
        // Parallel horizontals.
        v = '{-100, 5, 100, 5, -50, 40, 70, 40};
        r.pts = pack_pts(v);
        rows.push_back(r);
        r.fixed = 1'b0;
        v = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768};
        r.pts = pack_pts(v);
        rows.push_back(r);
        v = '{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768};
        r.pts = pack_pts(v);
        rows.push_back(r);
        // Nearly parallel at full scale, meeting at a shared end point.
        v = '{-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32767};
        r.pts = pack_pts(v);
        rows.push_back(r);
        v = '{32767, 32767, -32768, -32768, 32767, 32766, -32768, -32768};
        r.pts = pack_pts(v);
        rows.push_back(r);
        v = '{-32768, 32767, 32767, -32768, -32767, 32767, 32767, -32768};
        r.pts = pack_pts(v);
        rows.push_back(r);
        // Quotients that need truncation toward zero, both signs.
        v = '{0, 0, 3, 1, 0, 1, 3, 0};
        r.pts = pack_pts(v);
        rows.push_back(r);
        v = '{0, 0, -3, 1, 0, 1, -3, 0};
        r.pts = pack_pts(v);
        rows.push_back(r);
        r.pts = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h1234, 16'hedcb};
        rows.push_back(r);

        foreach (rows[i])
        begin
            pending_crossings.push_back(rows[i].fixed ? rows[i].ans
                                                      : compute_crossing(rows[i].pts));
            send_pair(rows[i].pts);
        end

        for (int n = 0; n < 1000; n++)
        begin
            logic [8*CW-1:0] p;
            send_calm = (n >= 400 && n < 550);
            recv_calm = send_calm;
            p = random_pair();
            pending_crossings.push_back(compute_crossing(p));
            send_pair(p);
        end
        s_tvalid  <= 1'b0;
        send_calm = 1'b0;
        recv_calm = 1'b0;

        waited = 0;
        while (pending_crossings.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);

        if (errors == 0 && pending_crossings.size() == 0)
            $display("line_line_intersection_unit_tb OK");
        else
            $display("line_line_intersection_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lli_pkg.sv
rtl/lli_front.sv
rtl/lli_div_cell.sv
rtl/line_line_intersection_unit.sv
tb/line_line_intersection_unit_tb.sv
